[rtl/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants for the sublist classifier
// Transaction structs, action and relation codes, controller states, and the
// control groups passed from the controller to the cell row.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int MAX_LEN    = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    ACT_APPEND_FIRST  = 2'd0,
    ACT_APPEND_SECOND = 2'd1,
    ACT_CLASSIFY      = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REL_EQUAL     = 2'd0,
    REL_SUBLIST   = 2'd1,
    REL_SUPERLIST = 2'd2,
    REL_UNEQUAL   = 2'd3
  } relation_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                   action;
    logic signed [ELEM_WIDTH-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    relation_e relation;
    logic      overflow;
  } out_item_t;

  // Controller to cell row: one shared group
  typedef struct packed {
    logic             first_we;
    logic             second_we;
    logic [IDX_W-1:0] wr_idx;
    logic             shift;
    logic             swap;
    logic             clear;
  } slc_ctrl_t;

  // Per-cell control after write address decode
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic shift;
    logic swap;
    logic clear;
  } cell_ctrl_t;

endpackage

[rtl/slc_cell.sv]
// ----------------------------------------------------------------------------
// slc_cell: one position of the comparison row
// Holds one element of each list. During a search the haystack column shifts
// toward cell zero while a match flag ripples one cell per cycle the other way.
// ----------------------------------------------------------------------------
module slc_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  slc_pkg::cell_ctrl_t             ctrl_i,
  input  logic [slc_pkg::ELEM_WIDTH-1:0]  value_i,
  input  logic [slc_pkg::ELEM_WIDTH-1:0]  hay_next_i,
  input  logic [slc_pkg::ELEM_WIDTH-1:0]  hay_bcast_i,
  input  logic                            flag_i,
  output logic [slc_pkg::ELEM_WIDTH-1:0]  hay_o,
  output logic                            flag_o
);
  import slc_pkg::*;

  logic [ELEM_WIDTH-1:0] first_q, first_d;
  logic [ELEM_WIDTH-1:0] second_q, second_d;
  logic                  flag_q, flag_d;
  logic [ELEM_WIDTH-1:0] needle;

  // Pick needle and haystack roles
  assign needle = ctrl_i.swap ? second_q : first_q;
  assign hay_o  = ctrl_i.swap ? first_q : second_q;
  assign flag_o = flag_q;

  // Load appends, shift the haystack column
  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (ctrl_i.load_first) begin
      first_d = value_i;
    end
    if (ctrl_i.load_second) begin
      second_d = value_i;
    end
    if (ctrl_i.shift) begin
      if (ctrl_i.swap) begin
        first_d = hay_next_i;
      end else begin
        second_d = hay_next_i;
      end
    end
  end

  // Advance the partial match flag
  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end else if (ctrl_i.shift) begin
      flag_d = flag_i && (hay_bcast_i == needle);
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

endmodule

[rtl/slc_ctrl.sv]
// ----------------------------------------------------------------------------
// slc_ctrl: sequencer for the sublist classifier
// Tracks list lengths and the drop flag, runs the search over the cell row
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module slc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [slc_pkg::MAX_LEN-1:0]  flags_i,
  output slc_pkg::slc_ctrl_t           ctrl_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output slc_pkg::out_item_t           out_data_o
);
  import slc_pkg::*;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] first_len_q, first_len_d;
  logic [LEN_W-1:0] second_len_q, second_len_d;
  logic             ovf_q, ovf_d;
  logic [LEN_W-1:0] needle_len_q, needle_len_d;
  logic [LEN_W-1:0] hay_len_q, hay_len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             swap_q, swap_d;
  logic             eq_q, eq_d;
  logic             ovf_lat_q, ovf_lat_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;
  logic [LEN_W-1:0] last_idx;
  logic             tail_hit;
  relation_e        rel;

  assign last_idx = needle_len_q - LEN_W'(1);
  assign tail_hit = flags_i[last_idx[IDX_W-1:0]];

  // Map the search outcome to a relation code
  always_comb begin
    if (!found_q) begin
      rel = REL_UNEQUAL;
    end else if (eq_q) begin
      rel = REL_EQUAL;
    end else if (swap_q) begin
      rel = REL_SUPERLIST;
    end else begin
      rel = REL_SUBLIST;
    end
  end

  // Next state, counters and row control
  always_comb begin
    state_d      = state_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    ovf_d        = ovf_q;
    needle_len_d = needle_len_q;
    hay_len_d    = hay_len_q;
    cnt_d        = cnt_q;
    swap_d       = swap_q;
    eq_d         = eq_q;
    ovf_lat_d    = ovf_lat_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    in_stall_o   = 1'b1;
    ctrl_o       = '0;
    ctrl_o.swap  = swap_q;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (action_i)
            ACT_APPEND_FIRST: begin
              if (first_len_q < LEN_W'(MAX_LEN)) begin
                ctrl_o.first_we = 1'b1;
                ctrl_o.wr_idx   = first_len_q[IDX_W-1:0];
                first_len_d     = first_len_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ACT_APPEND_SECOND: begin
              if (second_len_q < LEN_W'(MAX_LEN)) begin
                ctrl_o.second_we = 1'b1;
                ctrl_o.wr_idx    = second_len_q[IDX_W-1:0];
                second_len_d     = second_len_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ACT_CLASSIFY: begin
              swap_d       = first_len_q > second_len_q;
              eq_d         = first_len_q == second_len_q;
              needle_len_d = swap_d ? second_len_q : first_len_q;
              hay_len_d    = swap_d ? first_len_q : second_len_q;
              ovf_lat_d    = ovf_q;
              first_len_d  = '0;
              second_len_d = '0;
              ovf_d        = 1'b0;
              cnt_d        = '0;
              ctrl_o.clear = 1'b1;
              // An empty needle always occurs
              if (needle_len_d == '0) begin
                found_d = 1'b1;
                state_d = ST_DONE;
              end else begin
                found_d = 1'b0;
                state_d = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        ctrl_o.shift = 1'b1;
        found_d      = found_q || tail_hit;
        cnt_d        = cnt_q + LEN_W'(1);
        if (cnt_q == hay_len_q - LEN_W'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        found_d = found_q || tail_hit;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_data_d.relation = rel;
          out_data_d.overflow = ovf_lat_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_len_q  <= '0;
      second_len_q <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
      found_q      <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    needle_len_q <= needle_len_d;
    hay_len_q    <= hay_len_d;
    swap_q       <= swap_d;
    eq_q         <= eq_d;
    ovf_lat_q    <= ovf_lat_d;
    out_data_q   <= out_data_d;
  end

endmodule

[rtl/sublist_classifier_top.sv]
// ----------------------------------------------------------------------------
// sublist_classifier_top: contiguous sublist / superlist classifier
// Loads two lists of signed elements and reports their relation on classify.
// ----------------------------------------------------------------------------
// Appends are taken one per cycle and written into a row of MAX_LEN cells,
// each cell holding one element of each list. A classify transaction stalls
// the input while the longer list (the haystack) shifts through the row one
// position per cycle past the shorter list held in place, with a match flag
// rippling cell to cell; FINISH and DONE follow before the result register
// is loaded (straight to DONE when the shorter list is empty), with any wait
// in DONE for the previous result to be taken; the next input is accepted in
// the cycle after loading. Classify clears both lists and the drop flag;
// appends beyond MAX_LEN are dropped and flagged in the next result.
module sublist_classifier_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  slc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slc_pkg::out_item_t out_data_o
);
  import slc_pkg::*;

  slc_ctrl_t             ctrl;
  logic [MAX_LEN-1:0]    flags;
  logic [ELEM_WIDTH-1:0] hay [MAX_LEN];

  slc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (in_data_i.action),
    .flags_i     (flags),
    .ctrl_o      (ctrl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Build the cell row, decoding the write address per cell
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    cell_ctrl_t            cctrl;
    logic [ELEM_WIDTH-1:0] hay_next;
    logic                  flag_in;

    assign cctrl.load_first  = ctrl.first_we && (ctrl.wr_idx == IDX_W'(k));
    assign cctrl.load_second = ctrl.second_we && (ctrl.wr_idx == IDX_W'(k));
    assign cctrl.shift       = ctrl.shift;
    assign cctrl.swap        = ctrl.swap;
    assign cctrl.clear       = ctrl.clear;

    if (k == MAX_LEN - 1) begin : g_last
      assign hay_next = hay[k];
    end else begin : g_mid
      assign hay_next = hay[k+1];
    end

    if (k == 0) begin : g_head
      assign flag_in = 1'b1;
    end else begin : g_body
      assign flag_in = flags[k-1];
    end

    slc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cctrl),
      .value_i     (in_data_i.element_value),
      .hay_next_i  (hay_next),
      .hay_bcast_i (hay[0]),
      .flag_i      (flag_in),
      .hay_o       (hay[k]),
      .flag_o      (flags[k])
    );
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for sublist_classifier_top
// Streams append, classify and unused transactions into the classifier with
// random idle and stall cycles, keeps a copy of both lists alongside the
// block, and checks every classify result against the relation and drop flag
// predicted from that copy.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300_000;
  localparam int TAIL_CYCLES = MAX_LEN + 16;
  localparam int ITEM_TARGET = 1050;

  typedef struct packed {
    in_item_t item;
    logic     hold;   // wait for every pending result before sending
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  pending_t  pending_q[$];
  out_item_t relation_q[$];

  // Shadow copy of the two lists
  logic [ELEM_WIDTH-1:0] first_list[MAX_LEN];
  logic [ELEM_WIDTH-1:0] second_list[MAX_LEN];
  int   first_len = 0;
  int   second_len = 0;
  logic drop_seen = 1'b0;

  // Stimulus build area
  logic [ELEM_WIDTH-1:0] first_seq[$];
  logic [ELEM_WIDTH-1:0] second_seq[$];
  logic [ELEM_WIDTH-1:0] hay_seq[$];
  logic [ELEM_WIDTH-1:0] needle_seq[$];
  bit   noise_on = 1'b0;
  int   planned = 0;

  bit   in_taken = 1'b0;
  int   items_in = 0;
  int   cycles = 0;
  int   fail_count = 0;
  int   results_checked = 0;
  int   overflow_results = 0;
  int   rel_seen[4];

  wire calm = (items_in >= 400) && (items_in < 650);

  sublist_classifier_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True when the shorter list occurs contiguously in the longer one
  function automatic bit found_in(input bit first_is_needle);
    int  nlen;
    int  hlen;
    bit  hit;
    nlen = first_is_needle ? first_len : second_len;
    hlen = first_is_needle ? second_len : first_len;
    for (int s = 0; s <= hlen - nlen; s++) begin
      hit = 1'b1;
      for (int k = 0; k < nlen; k++) begin
        if (first_is_needle ? (first_list[k] != second_list[s + k])
                            : (second_list[k] != first_list[s + k])) hit = 1'b0;
      end
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic relation_e relation_now();
    if (first_len == second_len) begin
      for (int k = 0; k < first_len; k++) begin
        if (first_list[k] != second_list[k]) return REL_UNEQUAL;
      end
      return REL_EQUAL;
    end
    if (first_len < second_len) return found_in(1'b1) ? REL_SUBLIST : REL_UNEQUAL;
    return found_in(1'b0) ? REL_SUPERLIST : REL_UNEQUAL;
  endfunction

  // Update the shadow lists for one accepted transaction
  function automatic void advance_lists(input in_item_t t);
    out_item_t res;
    case (t.action)
      ACT_APPEND_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_list[first_len] = t.element_value;
          first_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ACT_APPEND_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_list[second_len] = t.element_value;
          second_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      ACT_CLASSIFY: begin
        res.relation = relation_now();
        res.overflow = drop_seen;
        relation_q.push_back(res);
        first_len = 0;
        second_len = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Mostly a tiny alphabet so that near matches are common
  function automatic logic [ELEM_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      5: return {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
      6: return {1'b1, {(ELEM_WIDTH - 1){1'b0}}};
      7: return '1;
      8: return $urandom;
      default: return ELEM_WIDTH'($urandom_range(3));
    endcase
  endfunction

  function automatic void queue_item(input logic [1:0] act,
                                     input logic [ELEM_WIDTH-1:0] value, input bit hold);
    pending_t p;
    p.item.action = act;
    p.item.element_value = value;
    p.hold = hold;
    pending_q.push_back(p);
    if (act != ACT_UNUSED) planned++;
  endfunction

  // Interleave the two built lists at random, then classify
  function automatic void emit_pair(input bit hold_first);
    int i;
    int j;
    bit lead;
    bit take_first;
    i = 0;
    j = 0;
    lead = hold_first;
    while (i < first_seq.size() || j < second_seq.size()) begin
      if (noise_on && $urandom_range(15) == 0) begin
        queue_item(ACT_UNUSED, pick_value(), lead);
        lead = 1'b0;
      end
      take_first = (j >= second_seq.size()) ||
                   (i < first_seq.size() && $urandom_range(1) == 1);
      if (take_first) begin
        queue_item(ACT_APPEND_FIRST, first_seq[i], lead);
        i++;
      end else begin
        queue_item(ACT_APPEND_SECOND, second_seq[j], lead);
        j++;
      end
      lead = 1'b0;
    end
    queue_item(ACT_CLASSIFY, pick_value(), lead);
  endfunction

  // Drive the next transaction at the falling edge; hold it while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_q.size() != 0 && !(pending_q[0].hold && relation_q.size() != 0) &&
            (calm || $urandom_range(99) >= 12)) begin
          in_data <= pending_q[0].item;
          in_valid <= 1'b1;
          pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  // Check results first, then predict from the accepted input
  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (relation_q.size() == 0) begin
          if (fail_count < 10)
            $display("cycle %0d: result with none expected, relation %0d overflow %0b",
                     cycles, out_data.relation, out_data.overflow);
          fail_count++;
        end else begin
          exp = relation_q.pop_front();
          if (out_data.relation !== exp.relation || out_data.overflow !== exp.overflow) begin
            if (fail_count < 10)
              $display("cycle %0d: expected relation %0d overflow %0b, got relation %0d overflow %0b",
                       cycles, exp.relation, exp.overflow, out_data.relation, out_data.overflow);
            fail_count++;
          end
          results_checked++;
          rel_seen[int'(exp.relation)]++;
          if (exp.overflow) overflow_results++;
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        items_in <= items_in + 1;
        advance_lists(in_data);
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int seq;
    int kind;
    int len;
    int start;
    int n;
    int idx;

    // Directed: empty lists, unused action, extremes, each relation
    queue_item(ACT_CLASSIFY, '0, 1'b0);
    queue_item(ACT_APPEND_FIRST, {1'b0, {(ELEM_WIDTH - 1){1'b1}}}, 1'b0);
    queue_item(ACT_UNUSED, '1, 1'b0);
    queue_item(ACT_APPEND_SECOND, {1'b0, {(ELEM_WIDTH - 1){1'b1}}}, 1'b0);
    queue_item(ACT_CLASSIFY, '0, 1'b0);
    first_seq = '{{1'b1, {(ELEM_WIDTH - 1){1'b0}}}};
    second_seq = '{'0, {1'b1, {(ELEM_WIDTH - 1){1'b0}}}, 5};
    emit_pair(1'b0);
    first_seq = '{1, 2};
    second_seq = '{2};
    emit_pair(1'b0);
    first_seq = '{'1};
    second_seq = '{{1'b0, {(ELEM_WIDTH - 1){1'b1}}}};
    emit_pair(1'b0);
    first_seq.delete();
    second_seq = '{9};
    emit_pair(1'b0);
    first_seq = '{9};
    second_seq.delete();
    emit_pair(1'b0);
    first_seq = '{1, 2};
    second_seq = '{2, 1, 3};
    emit_pair(1'b0);

    // Random: mostly related list pairs, with overflow and full-list cases up front
    noise_on = 1'b1;
    seq = 0;
    while (planned < ITEM_TARGET) begin
      kind = (seq < 3) ? 13 + seq : $urandom_range(16);
      len = ($urandom_range(9) == 0) ? $urandom_range(13, MAX_LEN) : $urandom_range(0, 12);
      if (kind == 13 || kind == 14) len = MAX_LEN + $urandom_range(1, 3);
      if (kind == 15) len = MAX_LEN;
      hay_seq.delete();
      repeat (len) hay_seq.push_back(pick_value());
      start = $urandom_range(0, len);
      n = $urandom_range(0, len - start);
      needle_seq.delete();
      for (int k = 0; k < n; k++) needle_seq.push_back(hay_seq[start + k]);
      case (kind)
        0, 1, 2: begin
          first_seq = hay_seq;
          second_seq = hay_seq;
        end
        3, 4, 5, 14: begin
          first_seq = needle_seq;
          second_seq = hay_seq;
        end
        6, 7, 8, 13: begin
          first_seq = hay_seq;
          second_seq = needle_seq;
        end
        9, 10: begin
          if (needle_seq.size() != 0) begin
            idx = $urandom_range(0, needle_seq.size() - 1);
            needle_seq[idx] = needle_seq[idx] ^ (ELEM_WIDTH'(1) << $urandom_range(ELEM_WIDTH - 1));
          end
          first_seq = $urandom_range(1) ? needle_seq : hay_seq;
          second_seq = (first_seq.size() == needle_seq.size() && $urandom_range(1))
                       ? hay_seq : ($urandom_range(1) ? hay_seq : needle_seq);
        end
        11, 12: begin
          first_seq = hay_seq;
          second_seq.delete();
          repeat ($urandom_range(0, 6)) second_seq.push_back(pick_value());
          if ($urandom_range(1)) begin
            needle_seq = first_seq;
            first_seq = second_seq;
            second_seq = needle_seq;
          end
        end
        15: begin
          first_seq = hay_seq;
          second_seq = hay_seq;
          if ($urandom_range(1)) second_seq[MAX_LEN - 1] = second_seq[MAX_LEN - 1] ^ 1;
        end
        default: begin
          first_seq.delete();
          second_seq.delete();
        end
      endcase
      emit_pair(seq == 4 || $urandom_range(24) == 0);
      seq++;
    end

    // Hold reset, then release it away from the rising edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain stimulus and results, then watch for stray output
    while (pending_q.size() != 0 || in_valid || relation_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d transactions; checked %0d classify results (%0d with dropped appends).",
             items_in, results_checked, overflow_results);
    $display("Relations equal/sublist/superlist/unequal: %0d/%0d/%0d/%0d; mismatches: %0d.",
             rel_seen[0], rel_seen[1], rel_seen[2], rel_seen[3], fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/slc_pkg.sv
rtl/slc_cell.sv
rtl/slc_ctrl.sv
rtl/sublist_classifier_top.sv
bench/tb.sv
